// ===== hdl/cev_pkg.sv =====
// ---------------------------------------------------------------------------
// cev_pkg: shared types and constants for COP0 exception vectoring
// Beat payloads, Status bit positions, vector bases and code values.
// ---------------------------------------------------------------------------
package cev_pkg;

    // Status register bit positions
    localparam int STATUS_EXL = 1;
    localparam int STATUS_ERL = 2;
    localparam int STATUS_BEV = 22;
    localparam int STATUS_DEV = 23;

    // Cause branch-delay bit
    localparam int CAUSE_BD = 31;

    // Vector bases and fixed targets
    localparam logic [31:0] VEC_BASE_LOW  = 32'h8000_0000;
    localparam logic [31:0] VEC_BASE_BOOT = 32'hBFC0_0200;
    localparam logic [31:0] RESET_VECTOR  = 32'hBFC0_0000;

    // Vector offsets
    localparam logic [31:0] OFS_TLB_REFILL = 32'h0000_0000;
    localparam logic [31:0] OFS_GENERAL    = 32'h0000_0180;
    localparam logic [31:0] OFS_INTERRUPT  = 32'h0000_0200;
    localparam logic [31:0] OFS_PERF       = 32'h0000_0080;
    localparam logic [31:0] OFS_DEBUG      = 32'h0000_0100;
    localparam logic [31:0] OFS_NONE       = 32'h0000_0000;

    // Excode values (code word bits 6:2)
    localparam logic [4:0] EXC_INT  = 5'd0;
    localparam logic [4:0] EXC_TLBL = 5'd2;
    localparam logic [4:0] EXC_TLBS = 5'd3;

    // Level-2 classes (code word bits 17:15)
    localparam logic [2:0] CLS_RESET = 3'd0;
    localparam logic [2:0] CLS_NMI   = 3'd1;
    localparam logic [2:0] CLS_PERF  = 3'd2;
    localparam logic [2:0] CLS_DEBUG = 3'd3;

    // Context / EntryHi field masks
    localparam logic [31:0] CONTEXT_KEEP_MASK = 32'hFF80_000F;
    localparam logic [31:0] CONTEXT_VPN_MASK  = 32'h007F_FFF0;
    localparam logic [31:0] ENTRYHI_VPN_MASK  = 32'hFFFF_E000;
    localparam logic [31:0] ENTRYHI_KEEP_MASK = 32'h0000_1FFF;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef enum logic {
        ACT_GENERAL  = 1'b0,
        ACT_TLB_MISS = 1'b1
    } cev_action_t;

    typedef struct packed {
        logic        action;
        logic [23:0] exception_code;
        logic        in_delay_slot;
        logic [31:0] current_pc;
        logic [31:0] fault_address;
        logic [31:0] status_word;
        logic [31:0] epc_in;
        logic [31:0] context_in;
        logic [31:0] entryhi_in;
    } cev_in_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] status_out;
        logic [31:0] cause_out;
        logic [31:0] epc_out;
        logic [31:0] badvaddr_out;
        logic        badvaddr_write;
        logic [31:0] context_out;
        logic [31:0] entryhi_out;
        logic        reset_vector_taken;
    } cev_out_t;

endpackage

// ===== hdl/cev_if.sv =====
// ---------------------------------------------------------------------------
// cev_if: valid/ready channels for request and result beats
// One interface per direction; source drives valid and data, sink drives ready.
// ---------------------------------------------------------------------------
interface cev_in_if;
    logic             valid;
    logic             ready;
    cev_pkg::cev_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cev_out_if;
    logic              valid;
    logic              ready;
    cev_pkg::cev_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/cop0_exception_vectoring.sv =====
// ---------------------------------------------------------------------------
// cop0_exception_vectoring: COP0 exception vector and register update
// Registered request -> vector logic -> registered result.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one exception request per beat: action, code word, delay
//   slot flag, PC and the current Status/EPC/Context/EntryHi values.
//   rsp returns one result beat per request: next fetch PC, updated
//   Status/Cause/EPC, BadVAddr with its write strobe, Context, EntryHi and
//   a flag for the reset/NMI vector.
//   A request passes the input register, then the result register, before
//   its result is valid.
//   Throughput: one beat per cycle while rsp.ready is high, set by the
//   two register stages; the vector logic between them is two subtracts,
//   an add and a few muxes. Stall: when rsp.ready is low the result
//   register holds its beat and the input register takes at most one more
//   beat; req.ready then drops. Results leave strictly in request order.
//   Reset: rst_n (async, active low) empties both stages; no beat is
//   pending afterward. There is no other state.
// ---------------------------------------------------------------------------
module cop0_exception_vectoring (
    input  logic      clk,
    input  logic      rst_n,
    cev_in_if.sink    req,
    cev_out_if.source rsp
);
    import cev_pkg::*;

    logic     stage_valid;
    cev_in_t  stage_data;
    logic     stage_ready;
    cev_out_t result;

    // request register
    cev_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .down_ready  (stage_ready),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    // vector selection and register updates
    cev_vector u_vector (
        .item   (stage_data),
        .result (result)
    );

    // result register, parts the receiver from the request side
    cev_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid),
        .up_data  (result),
        .up_ready (stage_ready),
        .rsp      (rsp)
    );
endmodule

// ===== hdl/cev_in_stage.sv =====
// ---------------------------------------------------------------------------
// cev_in_stage: request input register
// Captures a request beat whenever the stage is empty or draining.
// ---------------------------------------------------------------------------
module cev_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    cev_in_if.sink           req,
    input  logic             down_ready,
    output logic             stage_valid,
    output cev_pkg::cev_in_t stage_data
);
    import cev_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    cev_in_t data_reg;
    logic    load;

    assign req.ready  = !valid_reg || down_ready;
    assign load       = req.valid && req.ready;
    assign valid_next = load ? 1'b1 : (down_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= req.data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;
endmodule

// ===== hdl/cev_vector.sv =====
// ---------------------------------------------------------------------------
// cev_vector: exception vector and COP0 register update logic
// Pure combinational; one request in, one result out.
// ---------------------------------------------------------------------------
module cev_vector (
    input  cev_pkg::cev_in_t  item,
    output cev_pkg::cev_out_t result
);
    import cev_pkg::*;

    logic [31:0] pc_eff;
    logic [4:0]  excode;
    logic [2:0]  lvl2_cls;
    logic        erl;
    logic        exl;
    logic        low_base;
    logic        reset_path;
    logic [31:0] offset;
    logic [31:0] base;
    logic        tlb_miss;

    assign tlb_miss = (item.action == ACT_TLB_MISS);
    assign excode   = item.exception_code[6:2];
    assign lvl2_cls = item.exception_code[17:15];
    assign erl      = item.status_word[STATUS_ERL];
    assign exl      = item.status_word[STATUS_EXL];
    // TLB miss rewinds the PC one instruction before anything else
    assign pc_eff   = tlb_miss ? (item.current_pc - PC_STEP) : item.current_pc;

    always_comb
    begin
        reset_path = 1'b0;
        offset     = OFS_NONE;
        if (!erl)
        begin
            low_base = !item.status_word[STATUS_BEV];
            if (excode == EXC_TLBL || excode == EXC_TLBS)
                offset = OFS_TLB_REFILL;
            else if (excode == EXC_INT)
                offset = OFS_INTERRUPT;
            else
                offset = OFS_GENERAL;
        end
        else
        begin
            low_base = !item.status_word[STATUS_DEV];
            case (lvl2_cls)
                CLS_RESET, CLS_NMI: reset_path = 1'b1;
                CLS_PERF:           offset     = OFS_PERF;
                CLS_DEBUG:          offset     = OFS_DEBUG;
                default:            offset     = OFS_NONE;
            endcase
        end
        // nested exception goes to the general vector unless the reset path is taken
        if (exl)
            offset = OFS_GENERAL;
    end

    assign base = low_base ? VEC_BASE_LOW : VEC_BASE_BOOT;

    always_comb
    begin
        result.badvaddr_write     = tlb_miss;
        result.badvaddr_out       = tlb_miss ? item.fault_address : 32'd0;
        result.context_out        = tlb_miss
            ? ((item.context_in & CONTEXT_KEEP_MASK)
               | ((item.fault_address >> 9) & CONTEXT_VPN_MASK))
            : item.context_in;
        result.entryhi_out        = tlb_miss
            ? ((item.fault_address & ENTRYHI_VPN_MASK)
               | (item.entryhi_in & ENTRYHI_KEEP_MASK))
            : item.entryhi_in;
        result.reset_vector_taken = reset_path;
        result.status_out         = item.status_word;
        result.epc_out            = item.epc_in;
        result.cause_out          = {16'd0, item.exception_code[15:0]};

        if (reset_path)
        begin
            result.next_pc = RESET_VECTOR;
        end
        else
        begin
            result.next_pc = base + offset;
            if (!exl)
            begin
                result.status_out[STATUS_EXL] = 1'b1;
                result.epc_out = item.in_delay_slot ? (pc_eff - PC_STEP) : pc_eff;
                result.cause_out[CAUSE_BD] = item.in_delay_slot;
            end
        end
    end
endmodule

// ===== hdl/cev_out_stage.sv =====
// ---------------------------------------------------------------------------
// cev_out_stage: result output register
// Holds one result beat until the receiver takes it; refills on the same edge.
// ---------------------------------------------------------------------------
module cev_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  cev_pkg::cev_out_t up_data,
    output logic              up_ready,
    cev_out_if.source         rsp
);
    import cev_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    cev_out_t data_reg;
    logic     load;

    assign up_ready   = !valid_reg || rsp.ready;
    assign load       = up_valid && up_ready;
    assign valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= up_data;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;
endmodule
